[hw/rtl/crrvs_pkg.sv]
// Shared definitions for the credit round robin victim select block.
// Depends on nothing; used by credit_round_robin_victim_select.
package crrvs_pkg;

    // Default sizes handed to the top level.
    localparam int MAX_RANKS_DEF  = 16;
    localparam int COUNT_BITS_DEF = 16;

    // Stream payload widths, padded to whole bytes.
    localparam int S_TDATA_W = 48;
    localparam int M_TDATA_W = 24;

    // Config port.
    localparam int APB_ADDR_W = 4;
    localparam int APB_DATA_W = 32;

    // Register indexes, taken from paddr[3:2].
    localparam logic [1:0] REG_SELF_RANK    = 2'd0;
    localparam logic [1:0] REG_ACTIVE_RANKS = 2'd1;
    localparam logic [1:0] REG_WORKER_THR   = 2'd2;
    localparam logic [1:0] REG_MIN_JOBS     = 2'd3;

    // Operation codes.
    localparam logic [1:0] OP_SET_QUOTA = 2'd0;
    localparam logic [1:0] OP_RELOAD    = 2'd1;
    localparam logic [1:0] OP_SELECT    = 2'd2;
    localparam logic [1:0] OP_READ_MISS = 2'd3;

    // Floor of the local backlog threshold.
    localparam logic [19:0] BACKLOG_FLOOR = 20'd20;

    // Reset values of the config registers.
    localparam logic [4:0] ACTIVE_RANKS_RST = 5'd16;
    localparam logic [8:0] WORKER_THR_RST   = 9'd1;

endpackage

[hw/rtl/crrvs_ram.sv]
// Generic single write port, single read port RAM with registered read data.
// Depends on nothing.
module crrvs_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 16,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             aclk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write on enable, read every cycle.
    always_ff @(posedge aclk) begin
        if (we) begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

[hw/rtl/credit_round_robin_victim_select.sv]
// Credit based round robin victim select: picks the remote rank for the next
// offloaded task. One item at a time. Reload walks the N active ranks and
// select walks K (1..N) ranks up to the pick, each rank in a read / write
// or read / evaluate pair, as each store has a single read port with
// registered read data.
// A finished result waits in the output register while the next item enters.
// Depends on crrvs_pkg and crrvs_ram.
module credit_round_robin_victim_select
    import crrvs_pkg::*;
#(
    parameter int MAX_RANKS  = MAX_RANKS_DEF,
    parameter int COUNT_BITS = COUNT_BITS_DEF
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    // op[1:0], target_rank[5:2], quota_value[21:6], waiting_jobs[41:22]
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [S_TDATA_W-1:0]  s_tdata,
    // offload[0], victim_rank[4:1], missed_count[20:5]
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [M_TDATA_W-1:0]  m_tdata,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready
);

    localparam int RANK_W = $clog2(MAX_RANKS);
    localparam int NW     = $clog2(MAX_RANKS + 1);
    localparam int XW     = (NW > 5) ? NW : 5;
    localparam int CW     = (NW > 4) ? NW : 4;
    localparam int QW     = (COUNT_BITS > 16) ? COUNT_BITS : 16;
    localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;

    // Sequencer states.
    localparam logic [3:0] ST_IDLE    = 4'd0;
    localparam logic [3:0] ST_RL_RD   = 4'd1;
    localparam logic [3:0] ST_RL_WR   = 4'd2;
    localparam logic [3:0] ST_SEL_RD  = 4'd3;
    localparam logic [3:0] ST_SEL_EV  = 4'd4;
    localparam logic [3:0] ST_SEL_END = 4'd5;
    localparam logic [3:0] ST_MISS_WR = 4'd6;
    localparam logic [3:0] ST_RD_MISS = 4'd7;
    localparam logic [3:0] ST_OUT     = 4'd8;

    // Config registers.
    logic [3:0]  self_rank_reg;
    logic [4:0]  active_ranks_reg;
    logic [8:0]  worker_thr_reg;
    logic [10:0] min_jobs_reg;

    // Control state.
    logic [3:0]        state_reg, state_next;
    logic [RANK_W-1:0] ptr_reg, ptr_next;
    logic [NW-1:0]     cnt_reg, cnt_next;
    logic [RANK_W-1:0] rotate_reg, rotate_next;
    logic              picked_reg, picked_next;
    logic              m_tvalid_reg, m_tvalid_next;
    logic [MAX_RANKS-1:0] quota_vld_reg, credit_vld_reg, missed_vld_reg;

    // Payload state.
    logic [RANK_W-1:0] victim_p_reg, victim_p_next;
    logic [RANK_W-1:0] miss_addr_reg, miss_addr_next;
    logic [RANK_W-1:0] target_addr_reg, target_addr_next;
    logic [19:0]       waiting_reg, waiting_next;
    logic              res_offload_reg, res_offload_next;
    logic [3:0]        res_victim_reg, res_victim_next;
    logic [15:0]       res_missed_reg, res_missed_next;
    logic [M_TDATA_W-1:0] m_tdata_reg, m_tdata_next;
    logic [19:0]       thr_prod_reg;
    logic              quota_rvld_reg, credit_rvld_reg, missed_rvld_reg;

    // Input fields.
    logic [1:0]         op_in;
    logic [3:0]         target_in;
    logic signed [15:0] quota_in;
    logic [19:0]        waiting_in;

    assign op_in      = s_tdata[1:0];
    assign target_in  = s_tdata[5:2];
    assign quota_in   = s_tdata[21:6];
    assign waiting_in = s_tdata[41:22];

    // RAM ports.
    logic                  quota_we, credit_we, missed_we;
    logic [RANK_W-1:0]     quota_waddr, missed_waddr, missed_raddr;
    logic [COUNT_BITS-1:0] quota_wdata, credit_wdata, missed_wdata;
    logic [COUNT_BITS-1:0] quota_rdata, credit_rdata, missed_rdata;
    logic [COUNT_BITS-1:0] quota_val, credit_val, missed_val;

    // Config write and read.
    logic       cfg_wr;
    logic [1:0] cfg_idx;

    assign pready  = 1'b1;
    assign cfg_idx = paddr[3:2];
    assign cfg_wr  = psel & penable & pwrite & pready;

    always_comb begin
        case (cfg_idx)
            REG_SELF_RANK:    prdata = APB_DATA_W'(self_rank_reg);
            REG_ACTIVE_RANKS: prdata = APB_DATA_W'(active_ranks_reg);
            REG_WORKER_THR:   prdata = APB_DATA_W'(worker_thr_reg);
            REG_MIN_JOBS:     prdata = APB_DATA_W'(min_jobs_reg);
            default:          prdata = '0;
        endcase
    end

    // Effective rank count: zero acts as one, clamp at MAX_RANKS.
    logic [XW-1:0] act_x;
    logic [NW-1:0] n_eff;

    assign act_x = XW'(active_ranks_reg);

    always_comb begin
        if (act_x == '0) begin
            n_eff = NW'(1);
        end else if (act_x > XW'(MAX_RANKS)) begin
            n_eff = NW'(MAX_RANKS);
        end else begin
            n_eff = NW'(act_x);
        end
    end

    // Backlog threshold: product registered, add and floor at use.
    logic [8:0]  consumers;
    logic [19:0] thr_sum, thr_c;
    logic        backlog_low;

    assign consumers   = (worker_thr_reg > 9'd1) ? (worker_thr_reg - 9'd1) : 9'd1;
    assign thr_sum     = thr_prod_reg + 20'd1;
    assign thr_c       = (thr_sum > BACKLOG_FLOOR) ? thr_sum : BACKLOG_FLOOR;
    assign backlog_low = waiting_reg < thr_c;

    // Pointer and rank compares.
    logic [NW-1:0]     p_inc, cnt_inc;
    logic [RANK_W-1:0] p_wrap, start_ptr;
    logic              self_hit, tgt_ok, self_ok;

    assign p_inc     = NW'(ptr_reg) + NW'(1);
    assign p_wrap    = (p_inc == n_eff) ? '0 : p_inc[RANK_W-1:0];
    assign cnt_inc   = cnt_reg + NW'(1);
    assign start_ptr = (NW'(rotate_reg) < n_eff) ? rotate_reg : '0;
    assign self_hit  = CW'(ptr_reg) == CW'(self_rank_reg);
    assign tgt_ok    = CW'(target_in) < CW'(MAX_RANKS);
    assign self_ok   = CW'(self_rank_reg) < CW'(MAX_RANKS);

    // Entries never written read as zero.
    assign quota_val  = quota_rvld_reg  ? quota_rdata  : '0;
    assign credit_val = credit_rvld_reg ? credit_rdata : '0;
    assign missed_val = missed_rvld_reg ? missed_rdata : '0;

    // Shared count unit: zero and max test, decrement and increment.
    logic [COUNT_BITS-1:0] alu_a, alu_dec, alu_inc;
    logic                  alu_zero, alu_max;

    assign alu_a    = (state_reg == ST_MISS_WR) ? missed_val : credit_val;
    assign alu_zero = alu_a == '0;
    assign alu_max  = alu_a == COUNT_MAX;
    assign alu_dec  = alu_a - COUNT_BITS'(1);
    assign alu_inc  = alu_a + COUNT_BITS'(1);

    // Quota clamp: negative loads as zero, saturate to the count width.
    logic [15:0] quota_pos;
    logic [QW-1:0] quota_x;

    assign quota_pos   = quota_in[15] ? 16'd0 : $unsigned(quota_in);
    assign quota_x     = QW'(quota_pos);
    assign quota_wdata = (quota_x > QW'(COUNT_MAX)) ? COUNT_MAX : COUNT_BITS'(quota_x);
    assign quota_waddr = RANK_W'(target_in);

    // Missed count read back, saturated to 16 bits.
    logic [QW-1:0] missed_x;
    logic [15:0]   missed_sat;

    assign missed_x   = QW'(missed_val);
    assign missed_sat = (missed_x > QW'(16'hFFFF)) ? 16'hFFFF : missed_x[15:0];

    // Rank charged with a cancelled select.
    logic [RANK_W-1:0] miss_addr_c;

    assign miss_addr_c  = picked_reg ? victim_p_reg : RANK_W'(self_rank_reg);
    assign missed_raddr = (state_reg == ST_IDLE) ? RANK_W'(target_in) : miss_addr_c;
    assign missed_waddr = (state_reg == ST_MISS_WR) ? miss_addr_reg : target_addr_reg;

    // Sequencer.
    always_comb begin
        state_next       = state_reg;
        ptr_next         = ptr_reg;
        cnt_next         = cnt_reg;
        rotate_next      = rotate_reg;
        picked_next      = picked_reg;
        victim_p_next    = victim_p_reg;
        miss_addr_next   = miss_addr_reg;
        target_addr_next = target_addr_reg;
        waiting_next     = waiting_reg;
        res_offload_next = res_offload_reg;
        res_victim_next  = res_victim_reg;
        res_missed_next  = res_missed_reg;
        m_tdata_next     = m_tdata_reg;
        m_tvalid_next    = m_tvalid_reg & ~m_tready;
        quota_we         = 1'b0;
        credit_we        = 1'b0;
        credit_wdata     = '0;
        missed_we        = 1'b0;
        missed_wdata     = '0;

        case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    target_addr_next = RANK_W'(target_in);
                    waiting_next     = waiting_in;
                    res_offload_next = 1'b0;
                    res_victim_next  = self_rank_reg;
                    res_missed_next  = '0;
                    ptr_next         = '0;
                    cnt_next         = '0;
                    picked_next      = 1'b0;
                    case (op_in)
                        OP_SET_QUOTA: begin
                            quota_we   = tgt_ok;
                            state_next = ST_OUT;
                        end
                        OP_RELOAD: begin
                            state_next = ST_RL_RD;
                        end
                        OP_SELECT: begin
                            ptr_next   = start_ptr;
                            state_next = ST_SEL_RD;
                        end
                        OP_READ_MISS: begin
                            state_next = tgt_ok ? ST_RD_MISS : ST_OUT;
                        end
                        default: begin
                            state_next = ST_OUT;
                        end
                    endcase
                end
            end
            ST_RL_RD: begin
                state_next = ST_RL_WR;
            end
            ST_RL_WR: begin
                // copy quota to credit, skipping the local rank
                credit_we    = ~self_hit;
                credit_wdata = quota_val;
                ptr_next     = p_wrap;
                cnt_next     = cnt_inc;
                state_next   = (cnt_inc == n_eff) ? ST_OUT : ST_RL_RD;
            end
            ST_SEL_RD: begin
                state_next = ST_SEL_EV;
            end
            ST_SEL_EV: begin
                credit_we = 1'b1;
                ptr_next  = p_wrap;
                if (!self_hit && !alu_zero) begin
                    // take one credit and stop
                    credit_wdata  = alu_dec;
                    victim_p_next = ptr_reg;
                    picked_next   = 1'b1;
                    state_next    = ST_SEL_END;
                end else begin
                    // drop the credit of a passed rank
                    credit_wdata = '0;
                    cnt_next     = cnt_inc;
                    state_next   = (cnt_inc == n_eff) ? ST_SEL_END : ST_SEL_RD;
                end
            end
            ST_SEL_END: begin
                rotate_next = ptr_reg;
                if (backlog_low) begin
                    miss_addr_next = miss_addr_c;
                    state_next     = (picked_reg || self_ok) ? ST_MISS_WR : ST_OUT;
                end else begin
                    res_offload_next = picked_reg;
                    res_victim_next  = picked_reg ? 4'(victim_p_reg) : self_rank_reg;
                    state_next       = ST_OUT;
                end
            end
            ST_MISS_WR: begin
                missed_we    = ~alu_max;
                missed_wdata = alu_inc;
                state_next   = ST_OUT;
            end
            ST_RD_MISS: begin
                missed_we       = 1'b1;
                missed_wdata    = '0;
                res_missed_next = missed_sat;
                state_next      = ST_OUT;
            end
            ST_OUT: begin
                if (!m_tvalid_reg || m_tready) begin
                    m_tvalid_next = 1'b1;
                    m_tdata_next  = {3'b0, res_missed_reg, res_victim_reg, res_offload_reg};
                    state_next    = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control registers and config.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg        <= ST_IDLE;
            ptr_reg          <= '0;
            cnt_reg          <= '0;
            rotate_reg       <= '0;
            picked_reg       <= 1'b0;
            m_tvalid_reg     <= 1'b0;
            quota_vld_reg    <= '0;
            credit_vld_reg   <= '0;
            missed_vld_reg   <= '0;
            self_rank_reg    <= '0;
            active_ranks_reg <= ACTIVE_RANKS_RST;
            worker_thr_reg   <= WORKER_THR_RST;
            min_jobs_reg     <= '0;
        end else begin
            state_reg    <= state_next;
            ptr_reg      <= ptr_next;
            cnt_reg      <= cnt_next;
            rotate_reg   <= rotate_next;
            picked_reg   <= picked_next;
            m_tvalid_reg <= m_tvalid_next;
            if (quota_we) begin
                quota_vld_reg[quota_waddr] <= 1'b1;
            end
            if (credit_we) begin
                credit_vld_reg[ptr_reg] <= 1'b1;
            end
            if (missed_we) begin
                missed_vld_reg[missed_waddr] <= 1'b1;
            end
            if (cfg_wr) begin
                case (cfg_idx)
                    REG_SELF_RANK:    self_rank_reg    <= pwdata[3:0];
                    REG_ACTIVE_RANKS: active_ranks_reg <= pwdata[4:0];
                    REG_WORKER_THR:   worker_thr_reg   <= pwdata[8:0];
                    REG_MIN_JOBS:     min_jobs_reg     <= pwdata[10:0];
                    default: ;
                endcase
            end
        end
    end

    // Payload registers.
    always_ff @(posedge aclk) begin
        victim_p_reg    <= victim_p_next;
        miss_addr_reg   <= miss_addr_next;
        target_addr_reg <= target_addr_next;
        waiting_reg     <= waiting_next;
        res_offload_reg <= res_offload_next;
        res_victim_reg  <= res_victim_next;
        res_missed_reg  <= res_missed_next;
        m_tdata_reg     <= m_tdata_next;
        thr_prod_reg    <= 20'(consumers) * 20'(min_jobs_reg);
        quota_rvld_reg  <= quota_vld_reg[ptr_reg];
        credit_rvld_reg <= credit_vld_reg[ptr_reg];
        missed_rvld_reg <= missed_vld_reg[missed_raddr];
    end

    // Quota, credit and missed count stores.
    crrvs_ram #(
        .WIDTH (COUNT_BITS),
        .DEPTH (MAX_RANKS)
    ) u_quota_ram (
        .aclk  (aclk),
        .we    (quota_we),
        .waddr (quota_waddr),
        .wdata (quota_wdata),
        .raddr (ptr_reg),
        .rdata (quota_rdata)
    );

    crrvs_ram #(
        .WIDTH (COUNT_BITS),
        .DEPTH (MAX_RANKS)
    ) u_credit_ram (
        .aclk  (aclk),
        .we    (credit_we),
        .waddr (ptr_reg),
        .wdata (credit_wdata),
        .raddr (ptr_reg),
        .rdata (credit_rdata)
    );

    crrvs_ram #(
        .WIDTH (COUNT_BITS),
        .DEPTH (MAX_RANKS)
    ) u_missed_ram (
        .aclk  (aclk),
        .we    (missed_we),
        .waddr (missed_waddr),
        .wdata (missed_wdata),
        .raddr (missed_raddr),
        .rdata (missed_rdata)
    );

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    // Checks on the sequencer.
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_OUT) && m_tvalid_reg && !m_tready |=> (state_reg == ST_OUT))
        else $error("result stage left while the output register was still full");

    a_scan_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_SEL_EV) || (state_reg == ST_RL_WR) |-> (cnt_reg < n_eff))
        else $error("rank scan ran past the active rank count");

    a_idle_no_scan_wr: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_IDLE) |-> !credit_we && !missed_we)
        else $error("credit or missed store written while idle");

    a_offload_no_count: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid_reg && m_tdata_reg[0] |-> (m_tdata_reg[20:5] == 16'd0))
        else $error("offload result carries a missed count");

endmodule
